// ===== sv/aes_bme_pkg.sv =====
package aes_bme_pkg;

  typedef enum logic [2:0] {
    MODE_ECB_ENC = 3'd0,
    MODE_ECB_DEC = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CTR     = 3'd4
  } mode_e;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = $clog2(NumRounds + 1);

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_KEY_HIGH = 3'd1,
    REG_KEY_LOW  = 3'd2,
    REG_IV_HIGH  = 3'd3,
    REG_IV_LOW   = 3'd4,
    REG_OFFSET   = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_KEY,
    PH_ROUND
  } phase_e;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    gmul = (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00) ^
           (m[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [7:0] gmul_full(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p, x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul_full = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] inv, sq;
    // x^254 is the field inverse and maps zero to zero
    inv = 8'h01;
    sq  = x;
    for (int k = 1; k < 8; k++) begin
      sq  = gmul_full(sq, sq);
      inv = gmul_full(inv, sq);
    end
    sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
           {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t build_sbox();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox(8'(i));
    return t;
  endfunction

  function automatic sbox_t build_inv(input sbox_t s);
    sbox_t t;
    for (int i = 0; i < 256; i++) t[s[i]] = 8'(i);
    return t;
  endfunction

  localparam sbox_t SBox    = build_sbox();
  localparam sbox_t InvSBox = build_inv(SBox);

  typedef struct packed {
    logic         start;
    logic         decrypt;
    logic [127:0] din;
    logic [127:0] key;
  } aes_req_t;

endpackage

// ===== sv/aes128_block_mode_engine_core.sv =====
// AES-128 ECB/CBC/CTR engine. One 16-byte block per beat (tdata, byte 0 in
// the top of the high word), one result beat per input beat, and the input
// is not ready while a block is inside. A block that needs the cipher first
// expands the key schedule into a small round key memory, then runs the
// shared round unit, registers the done flag, holds its output beat until
// it is taken and then makes the input ready again. A block that only
// passes through (partial ECB/CBC block, unused mode) goes straight to the
// output beat. Registers sit at 8*i on the APB port; key, IV low and offset
// are sampled at the first block of each message, mode and IV high are used
// live.
module aes128_block_mode_engine_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [5:0]   paddr_i,
  input  logic [63:0]  pwdata_i,
  output logic [63:0]  prdata_o,
  output logic         pready_o,
  // tdata: data_high, data_low, byte_count (5b), zero pad
  input  logic [135:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: out_high, out_low
  output logic [127:0] m_axis_tdata_o,
  // tuser: status
  output logic         m_axis_tuser_o,
  output logic         m_axis_tlast_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);
  import aes_bme_pkg::*;

  logic [2:0]  mode_q;
  logic [63:0] keyh_q, keyl_q, ivh_q, ivl_q;
  logic [31:0] off_q;
  reg_e        widx;

  assign pready_o = 1'b1;
  assign widx = reg_e'(paddr_i[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0; keyh_q <= '0; keyl_q <= '0; ivh_q <= '0; ivl_q <= '0; off_q <= '0;
    end else if (psel_i && penable_i && pwrite_i) begin
      case (widx)
        REG_MODE:     mode_q <= pwdata_i[2:0];
        REG_KEY_HIGH: keyh_q <= pwdata_i;
        REG_KEY_LOW:  keyl_q <= pwdata_i;
        REG_IV_HIGH:  ivh_q  <= pwdata_i;
        REG_IV_LOW:   ivl_q  <= pwdata_i;
        REG_OFFSET:   off_q  <= pwdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODE:     prdata_o = {61'd0, mode_q};
      REG_KEY_HIGH: prdata_o = keyh_q;
      REG_KEY_LOW:  prdata_o = keyl_q;
      REG_IV_HIGH:  prdata_o = ivh_q;
      REG_IV_LOW:   prdata_o = ivl_q;
      REG_OFFSET:   prdata_o = {32'd0, off_q};
      default:      prdata_o = '0;
    endcase
  end

  // message state
  state_e state_q, state_d;
  logic first_q;
  logic [127:0] chain_q, din_q, key_q;
  logic [127:0] prev_chain_q;
  logic [63:0] ctr_q;
  logic [3:0]  skip_q;
  logic [4:0]  cnt_q;
  logic        last_q, status_q, use_aes_q;
  logic [2:0]  mode_s_q;

  function automatic logic [63:0] bswap(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = v[56 - 8*i +: 8];
    return r;
  endfunction

  logic [4:0]   in_cnt;
  logic [127:0] in_data;
  logic [127:0] chain_now;
  logic [63:0]  ctr_now;
  logic         acc;
  aes_req_t     req;
  logic         aes_busy, aes_done;
  logic [127:0] aes_out, fin;

  assign in_data = {s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]};
  assign in_cnt  = (s_axis_tdata_i[132:128] > 5'd16) ? 5'd16 : s_axis_tdata_i[132:128];
  assign acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign chain_now = first_q ? {ivh_q, ivl_q} : chain_q;
  assign ctr_now   = first_q ? bswap(ivl_q) + {36'd0, off_q[31:4]} : ctr_q;

  always_comb begin
    req.start   = 1'b0;
    req.decrypt = 1'b0;
    req.key     = first_q ? {keyh_q, keyl_q} : key_q;
    req.din     = in_data;
    if (acc) begin
      case (mode_q)
        MODE_ECB_ENC: begin req.start = in_cnt == 5'd16; end
        MODE_ECB_DEC: begin req.start = in_cnt == 5'd16; req.decrypt = 1'b1; end
        MODE_CBC_ENC: begin req.start = in_cnt == 5'd16; req.din = in_data ^ chain_now; end
        MODE_CBC_DEC: begin req.start = in_cnt == 5'd16; req.decrypt = 1'b1; end
        MODE_CTR: begin
          req.start = 1'b1;
          req.din   = {ivh_q, bswap(ctr_now)};
        end
        default: ;
      endcase
    end
  end

  aes_bme_round u_round (
    .clk_i, .rst_ni, .req_i(req), .busy_o(aes_busy), .done_o(aes_done), .dout_o(aes_out)
  );

  // final combine, bytes below count kept, rest zeroed
  always_comb begin
    fin = din_q;
    case (mode_s_q)
      MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC: if (use_aes_q) fin = aes_out;
      MODE_CBC_DEC: if (use_aes_q) fin = aes_out ^ prev_chain_q;
      MODE_CTR: begin
        for (int i = 0; i < 16; i++)
          if (4'(i) >= skip_q)
            fin[127 - 8*i -: 8] = din_q[127 - 8*i -: 8] ^ aes_out[127 - 8*i -: 8];
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++)
      if (5'(i) >= cnt_q) fin[127 - 8*i -: 8] = 8'h00;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc) state_d = req.start ? ST_RUN : ST_OUT;
      ST_RUN:  if (aes_done) state_d = ST_OUT;
      ST_OUT:  if (m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = state_q == ST_IDLE && !aes_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; first_q <= 1'b1; chain_q <= '0; ctr_q <= '0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        first_q <= s_axis_tlast_i;
        ctr_q   <= ctr_now + ((mode_q == MODE_CTR) ? 64'd1 : 64'd0);
        if (mode_q == MODE_CBC_DEC && in_cnt == 5'd16) chain_q <= in_data;
        else chain_q <= chain_now;
      end
      if (state_q == ST_RUN && aes_done && mode_s_q == MODE_CBC_ENC) chain_q <= aes_out;
    end
  end

  // cbc decrypt needs the old chain at output time
  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_chain_q <= chain_now;
      din_q     <= in_data;
      cnt_q     <= s_axis_tdata_i[132:128] == 5'd0 ? 5'd0 : in_cnt;
      last_q    <= s_axis_tlast_i;
      mode_s_q  <= mode_q;
      use_aes_q <= req.start;
      skip_q    <= first_q ? off_q[3:0] : 4'd0;
      status_q  <= mode_q <= MODE_CBC_DEC && in_cnt != 5'd16 && first_q && s_axis_tlast_i;
      key_q     <= req.key;
    end
  end

  assign m_axis_tdata_o  = {fin[63:0], fin[127:64]};
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tvalid_o = state_q == ST_OUT;
endmodule

// ===== sv/aes_bme_round.sv =====
module aes_bme_round (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  aes_bme_pkg::aes_req_t    req_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [127:0]             dout_o
);
  import aes_bme_pkg::*;

  // forward round keys expanded one per cycle, decrypt walks them back
  logic [127:0] rk_mem [NumRounds + 1];
  logic [127:0] st_q, st_d, rk_q, rk_d, rkr_q;
  logic [RoundW-1:0] rnd_q, rnd_d;
  phase_e ph_q, ph_d;
  logic dec_q, dec_d, done_q, done_d;
  logic [7:0] rcon_q, rcon_d;
  logic [RoundW-1:0] rd_idx;
  logic [127:0] rnd_out, nxt_key;

  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    t = {SBox[w3[23:16]] ^ rc, SBox[w3[15:8]], SBox[w3[7:0]], SBox[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBox[s[127 - 8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int q = 0; q < 4; q++) t[c*4 + q] = b[((c + q) % 4)*4 + q];
    for (int c = 0; c < 4; c++)
      for (int q = 0; q < 4; q++)
        o[c*4 + q] = last ? t[c*4 + q] :
          gmul(t[c*4 + q], 4'd2) ^ gmul(t[c*4 + (q+1)%4], 4'd3) ^
          t[c*4 + (q+2)%4] ^ t[c*4 + (q+3)%4];
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = o[i];
    return r;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
    if (mix) begin
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++)
          t[c*4 + q] = gmul(b[c*4 + q], 4'd14) ^ gmul(b[c*4 + (q+1)%4], 4'd11) ^
            gmul(b[c*4 + (q+2)%4], 4'd13) ^ gmul(b[c*4 + (q+3)%4], 4'd9);
    end else begin
      for (int i = 0; i < 16; i++) t[i] = b[i];
    end
    for (int c = 0; c < 4; c++)
      for (int q = 0; q < 4; q++) o[((c + q) % 4)*4 + q] = InvSBox[t[c*4 + q]];
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = o[i];
    return r;
  endfunction

  assign nxt_key = key_step(rk_q, rcon_q);

  // decrypt state kept as (s ^ k) with invmix applied after key add
  always_comb begin
    if (dec_q) rnd_out = dec_round(st_q, rnd_q != RoundW'(0)) ^ rkr_q;
    else       rnd_out = enc_round(st_q, rnd_q == RoundW'(NumRounds - 1)) ^ rkr_q;
  end

  always_comb begin
    ph_d = ph_q; rnd_d = rnd_q; st_d = st_q; rk_d = rk_q; dec_d = dec_q;
    rcon_d = rcon_q; done_d = 1'b0;
    case (ph_q)
      PH_IDLE: begin
        if (req_i.start) begin
          ph_d = PH_KEY; rnd_d = '0; st_d = req_i.din; rk_d = req_i.key;
          dec_d = req_i.decrypt; rcon_d = 8'h01;
        end
      end
      PH_KEY: begin
        rk_d = nxt_key; rcon_d = xt(rcon_q); rnd_d = rnd_q + RoundW'(1);
        if (rnd_q == RoundW'(NumRounds - 1)) begin
          ph_d = PH_ROUND; rnd_d = '0;
          st_d = st_q ^ (dec_q ? nxt_key : rk_mem[0]);
        end
      end
      PH_ROUND: begin
        st_d = rnd_out; rnd_d = rnd_q + RoundW'(1);
        if (rnd_q == RoundW'(NumRounds - 1)) begin
          ph_d = PH_IDLE; done_d = 1'b1;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  // round key for the round that runs in the next cycle
  assign rd_idx = dec_q ? RoundW'(NumRounds - 1) - rnd_d : rnd_d + RoundW'(1);

  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && req_i.start) rk_mem[0] <= req_i.key;
    if (ph_q == PH_KEY) rk_mem[rnd_q + RoundW'(1)] <= nxt_key;
    if (ph_d == PH_ROUND) rkr_q <= rk_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; done_q <= 1'b0; rnd_q <= '0; dec_q <= 1'b0; rcon_q <= 8'h01;
    end else begin
      ph_q <= ph_d; done_q <= done_d; rnd_q <= rnd_d; dec_q <= dec_d; rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
  end

  assign busy_o = ph_q != PH_IDLE;
  assign done_o = done_q;
  assign dout_o = st_q;
endmodule

// ===== bench/aes128_block_mode_engine_core_test.sv =====
module aes128_block_mode_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_bme_pkg::*;

  typedef struct {
    bit [127:0] blk;
    bit         status;
    bit         last;
  } aes_beat_t;

  // predicts the engine block by block and holds the result beats still owed
  class aes_mode_scoreboard;
    bit [7:0]   fwd_box[256];
    bit [7:0]   inv_box[256];
    bit [2:0]   mode;
    bit [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    bit [31:0]  offset;
    bit [127:0] chain;
    bit [63:0]  ctr;
    bit [127:0] rk[11];
    bit         first_blk;
    aes_beat_t  owed_q[$];
    int         errors;

    function new();
      bit [7:0] inv;
      bit [7:0] s;
      for (int x = 0; x < 256; x++) begin
        inv = 0;
        if (x != 0)
          for (int b = 1; b < 256; b++)
            if (gmul(8'(x), 8'(b)) == 8'h01) inv = 8'(b);
        s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
            {inv[3:0], inv[7:4]} ^ 8'h63;
        fwd_box[x] = s;
      end
      for (int x = 0; x < 256; x++) inv_box[fwd_box[x]] = 8'(x);
      first_blk = 1;
    endfunction

    function bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
      bit [8:0] x;
      bit [7:0] p;
      p = 0;
      x = {1'b0, a};
      for (int i = 0; i < 8; i++) begin
        if (b[i]) p ^= x[7:0];
        x = x << 1;
        if (x[8]) x ^= 9'h11b;
      end
      return p;
    endfunction

    function void set_reg(reg_e idx, bit [63:0] v);
      case (idx)
        REG_MODE:     mode = v[2:0];
        REG_KEY_HIGH: key_hi = v;
        REG_KEY_LOW:  key_lo = v;
        REG_IV_HIGH:  iv_hi = v;
        REG_IV_LOW:   iv_lo = v;
        REG_OFFSET:   offset = v[31:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] bswap(bit [63:0] v);
      bit [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = v[56-8*i +: 8];
      return r;
    endfunction

    function void expand_key();
      bit [31:0] w[44];
      bit [31:0] t;
      bit [7:0]  rcon;
      rcon = 8'h01;
      {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
      for (int i = 4; i < 44; i++) begin
        t = w[i-1];
        if ((i % 4) == 0) begin
          t = {t[23:0], t[31:24]};
          t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
          t ^= {rcon, 24'h0};
          rcon = gmul(rcon, 8'h02);
        end
        w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r <= 10; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    // byte i sits at bits 127-8i down
    function bit [127:0] sub(bit [127:0] v, bit inv);
      for (int i = 0; i < 16; i++)
        v[127-8*i -: 8] = inv ? inv_box[v[127-8*i -: 8]] : fwd_box[v[127-8*i -: 8]];
      return v;
    endfunction

    function bit [127:0] shift(bit [127:0] v, bit inv);
      bit [127:0] o;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          if (inv) o[127-8*(((c+r)%4)*4+r) -: 8] = v[127-8*(c*4+r) -: 8];
          else o[127-8*(c*4+r) -: 8] = v[127-8*(((c+r)%4)*4+r) -: 8];
      return o;
    endfunction

    function bit [127:0] mix(bit [127:0] v, bit inv);
      bit [7:0] a[4];
      bit [7:0] m[4];
      bit [127:0] o;
      if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = v[127-8*(4*c+r) -: 8];
        for (int r = 0; r < 4; r++)
          o[127-8*(4*c+r) -: 8] = gmul(a[r], m[0]) ^ gmul(a[(r+1)%4], m[1]) ^
                                  gmul(a[(r+2)%4], m[2]) ^ gmul(a[(r+3)%4], m[3]);
      end
      return o;
    endfunction

    function bit [127:0] encipher(bit [127:0] s);
      s ^= rk[0];
      for (int r = 1; r < 10; r++) s = mix(shift(sub(s, 0), 0), 0) ^ rk[r];
      return shift(sub(s, 0), 0) ^ rk[10];
    endfunction

    function bit [127:0] decipher(bit [127:0] s);
      s ^= rk[10];
      for (int r = 9; r >= 1; r--) s = mix(sub(shift(s, 1), 1) ^ rk[r], 1);
      return sub(shift(s, 1), 1) ^ rk[0];
    endfunction

    function void note_block(bit [135:0] d, bit last);
      bit [127:0] din, o, ks;
      int         cnt, skip;
      aes_beat_t  e;
      din  = {d[63:0], d[127:64]};
      cnt  = d[132:128] > 16 ? 16 : d[132:128];
      skip = 0;
      e.status = 0;
      if (first_blk) begin
        expand_key();
        chain = {iv_hi, iv_lo};
        ctr   = bswap(iv_lo) + 64'(offset >> 4);
        skip  = offset[3:0];
      end
      o = din;
      if (mode <= MODE_CBC_DEC) begin
        if (cnt < 16) begin
          if (first_blk && last) e.status = 1;
        end else if (mode == MODE_ECB_ENC) begin
          o = encipher(din);
        end else if (mode == MODE_ECB_DEC) begin
          o = decipher(din);
        end else if (mode == MODE_CBC_ENC) begin
          o = encipher(din ^ chain);
          chain = o;
        end else begin
          o = decipher(din) ^ chain;
          chain = din;
        end
      end else if (mode == MODE_CTR) begin
        ks = encipher({iv_hi, bswap(ctr)});
        for (int i = skip; i < 16; i++) o[127-8*i -: 8] ^= ks[127-8*i -: 8];
        ctr++;
      end
      for (int i = cnt; i < 16; i++) o[127-8*i -: 8] = 0;
      e.blk  = o;
      e.last = last;
      owed_q.push_back(e);
      first_blk = last;
    endfunction

    function void check_result(bit [127:0] td, bit st, bit ls);
      aes_beat_t e;
      bit [127:0] got;
      got = {td[63:0], td[127:64]};
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing owed: %h", got);
        return;
      end
      e = owed_q.pop_front();
      if (got !== e.blk || st !== e.status || ls !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: block exp %h got %h, status exp %0b got %0b, last exp %0b got %0b",
                   e.blk, got, e.status, st, e.last, ls);
      end
    endfunction
  endclass

  logic         clk_i, rst_ni;
  logic         psel_i, penable_i, pwrite_i;
  logic [5:0]   paddr_i;
  logic [63:0]  pwdata_i, prdata_o;
  logic         pready_o;
  logic [135:0] s_axis_tdata_i;
  logic         s_axis_tlast_i, s_axis_tvalid_i, s_axis_tready_o;
  logic [127:0] m_axis_tdata_o;
  logic         m_axis_tuser_o, m_axis_tlast_o, m_axis_tvalid_o, m_axis_tready_i;

  aes128_block_mode_engine_core dut (.*);

  aes_mode_scoreboard blocks_sb = new();
  int blocks_sent;
  int burst_left;
  bit hold_req;
  int hold_cnt;
  int pat_kind, pat_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // both monitors sample at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) blocks_sb.note_block(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        blocks_sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (pat_left == 0) begin
      pat_kind = $urandom_range(0, 3);
      pat_left = $urandom_range(20, 150);
    end
    pat_left--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (pat_kind)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= $urandom_range(0, 1);
        2: m_axis_tready_i <= ($urandom_range(0, 9) != 0);
        default: m_axis_tready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  initial begin
    #5ms;
    $display("aes128_block_mode_engine_core verification failed");
    $finish;
  end

  task automatic apb_write(reg_e idx, bit [63:0] v);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 6'(8 * idx);
    pwdata_i  <= v;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    blocks_sb.set_reg(idx, v);
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // pause the sender until every owed result has come, then let the core settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (blocks_sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_block(bit [127:0] blk, bit [4:0] cnt, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b0, cnt, blk[63:0], blk[127:64]};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    blocks_sent++;
  endtask

  function automatic bit [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one message of random content; odd byte counts now and then
  task automatic send_message(int n);
    bit [4:0] cnt;
    for (int b = 0; b < n; b++) begin
      cnt = 16;
      if (b == n - 1 && $urandom_range(0, 2) == 0) cnt = $urandom_range(1, 16);
      if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 31);
      send_block({rand_word(), rand_word()}, cnt, b == n - 1);
    end
  endtask

  task automatic set_all(bit [2:0] md, bit [127:0] key, bit [127:0] iv, bit [31:0] off);
    apb_write(REG_MODE, md);
    apb_write(REG_KEY_HIGH, key[127:64]);
    apb_write(REG_KEY_LOW, key[63:0]);
    apb_write(REG_IV_HIGH, iv[127:64]);
    apb_write(REG_IV_LOW, iv[63:0]);
    apb_write(REG_OFFSET, off);
  endtask

  initial begin
    bit [127:0] fips_key, fips_pt;
    bit [2:0]   md;
    bit [31:0]  off;
    bit         held;
    fips_key = 128'h000102030405060708090a0b0c0d0e0f;
    fips_pt  = 128'h00112233445566778899aabbccddeeff;
    held = 0;
    rst_ni = 1'b0;
    psel_i = 0; penable_i = 0; pwrite_i = 0; paddr_i = 0; pwdata_i = 0;
    s_axis_tdata_i = 0; s_axis_tlast_i = 0; s_axis_tvalid_i = 0;
    m_axis_tready_i = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: known key in ECB and CTR, all-ones key in CBC, extremes, partial and odd counts
    set_all(MODE_ECB_ENC, fips_key, '0, 0);
    send_block(fips_pt, 16, 1);
    send_block('1, 16, 1);
    send_block(fips_pt, 5, 1);          // no full block, error status
    drain();
    apb_write(REG_MODE, MODE_ECB_DEC);
    send_block(128'h69c4e0d86a7b0430d8cdb78070b4c55a, 16, 1);
    send_block('0, 0, 1);               // zero byte count
    drain();
    set_all(MODE_CBC_ENC, '1, '1, '1);
    send_block(fips_pt, 16, 0);
    send_block('1, 31, 0);              // count above sixteen
    send_block(fips_pt, 7, 0);          // partial in the middle
    send_block('0, 16, 1);
    drain();
    apb_write(REG_MODE, MODE_CBC_DEC);
    send_block(fips_pt, 16, 0);
    send_block('1, 16, 1);
    drain();
    // counter wraps; offset skips bytes of the first block and two blocks
    set_all(MODE_CTR, fips_key, {64'hdeadbeef01234567, 64'hfeffffffffffffff}, 32'h25);
    send_block(fips_pt, 16, 0);
    send_block('1, 16, 0);
    send_block(fips_pt, 16, 0);
    send_block(fips_pt, 3, 1);
    drain();
    apb_write(REG_OFFSET, 32'hffffffff);
    send_block('1, 16, 1);
    drain();
    apb_write(REG_MODE, 3'd7);          // unused mode code
    send_block(fips_pt, 16, 0);
    send_block(fips_pt, 9, 1);
    drain();

    while (blocks_sent < 550) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        md = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
          0: off = 0;
          1: off = '1;
          2: off = $urandom_range(0, 63);
          default: off = $urandom;
        endcase
        set_all(md, {rand_word(), rand_word()}, {rand_word(), rand_word()}, off);
      end
      if (!held && blocks_sent > 200) begin
        held = 1;
        hold_req = 1;
        send_message(30);
      end else begin
        send_message($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 8));
      end
    end
    drain();

    if (blocks_sb.errors == 0)
      $display("aes128_block_mode_engine_core verification clean");
    else
      $display("aes128_block_mode_engine_core verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/aes_bme_pkg.sv
sv/aes_bme_round.sv
sv/aes128_block_mode_engine_core.sv
bench/aes128_block_mode_engine_core_test.sv
